// ===== design/umr_pkg.sv =====
package umr_pkg;

    // Register map; register i sits at byte address 4*i.
    typedef enum logic [2:0] {
        REG_TRIGGER_WIDTH   = 3'd0,
        REG_RISE_WAIT_LIMIT = 3'd1,
        REG_ECHO_LIMIT      = 3'd2,
        REG_TICKS_PER_UNIT  = 3'd3,
        REG_GAP_TICKS       = 3'd4
    } t_reg_idx;

    // Upper nibble of a received command byte.
    typedef enum logic [3:0] {
        CMD_NOP       = 4'd0,
        CMD_SET_COUNT = 4'd1,
        CMD_GET_COUNT = 4'd2,
        CMD_READ      = 4'd3
    } t_cmd;

    localparam logic [7:0]  RST_TRIGGER_WIDTH   = 8'd10;
    localparam logic [15:0] RST_RISE_WAIT_LIMIT = 16'd1000;
    localparam logic [15:0] RST_ECHO_LIMIT      = 16'd11600;
    localparam logic [7:0]  RST_TICKS_PER_UNIT  = 8'd58;
    localparam logic [16:0] RST_GAP_TICKS       = 17'd50000;
    localparam logic [3:0]  RST_STORED_COUNT    = 4'd8;

    localparam logic [7:0]  REPLY_ERROR = 8'hFF;
    localparam logic [7:0]  REPLY_OK    = 8'h00;
    localparam logic [7:0]  DIST_MAX    = 8'hFF;

    // Number of physical trigger and echo pins.
    localparam int unsigned NUM_PINS = 8;

endpackage

// ===== design/multi_ultrasonic_ranger_spi.sv =====
// A request is registered in stage one, then written into the output queue, from which
// its result is offered on the result port.
// Throughput: one request (tick or command byte) per cycle while results drain; the input
// stalls only when the two-entry output queue plus the request in flight would overflow.
// Reset: synchronous, active low; all control state and registers take their defaults.
// The readings memory needs no clearing pass: per-entry valid bits make it read zero.
module multi_ultrasonic_ranger_spi #(
    parameter int SENSORS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_echo_levels,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_reply_byte,
    output logic        o_reply_valid,
    output logic [7:0]  o_trigger_lines,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    // The ranging sequencer has four phases per sensor; a zero gap setting skips the gap phase.
    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_RISE    = 2'd1,
        PH_ECHO    = 2'd2,
        PH_GAP     = 2'd3
    } t_phase;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land at the access phase of the
    // port; reads are answered combinationally from the same registers.
    // ------------------------------------------------------------------
    logic [7:0]  r_trigger_width;
    logic [15:0] r_rise_wait_limit;
    logic [15:0] r_echo_limit;
    logic [7:0]  r_ticks_per_unit;
    logic [16:0] r_gap_ticks;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_width   <= umr_pkg::RST_TRIGGER_WIDTH;
            r_rise_wait_limit <= umr_pkg::RST_RISE_WAIT_LIMIT;
            r_echo_limit      <= umr_pkg::RST_ECHO_LIMIT;
            r_ticks_per_unit  <= umr_pkg::RST_TICKS_PER_UNIT;
            r_gap_ticks       <= umr_pkg::RST_GAP_TICKS;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                umr_pkg::REG_TRIGGER_WIDTH:   r_trigger_width   <= pwdata[7:0];
                umr_pkg::REG_RISE_WAIT_LIMIT: r_rise_wait_limit <= pwdata[15:0];
                umr_pkg::REG_ECHO_LIMIT:      r_echo_limit      <= pwdata[15:0];
                umr_pkg::REG_TICKS_PER_UNIT:  r_ticks_per_unit  <= pwdata[7:0];
                umr_pkg::REG_GAP_TICKS:       r_gap_ticks       <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            umr_pkg::REG_TRIGGER_WIDTH:   prdata = {24'd0, r_trigger_width};
            umr_pkg::REG_RISE_WAIT_LIMIT: prdata = {16'd0, r_rise_wait_limit};
            umr_pkg::REG_ECHO_LIMIT:      prdata = {16'd0, r_echo_limit};
            umr_pkg::REG_TICKS_PER_UNIT:  prdata = {24'd0, r_ticks_per_unit};
            umr_pkg::REG_GAP_TICKS:       prdata = {15'd0, r_gap_ticks};
            default:                      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output queue bookkeeping. Stage one always pushes its result into
    // the queue, so a request is only taken when the queue is sure to
    // have room for it when stage one pushes it.
    // ------------------------------------------------------------------
    logic [1:0] r_count;
    logic       r_s1_valid;
    logic       pop;
    logic [2:0] occ_after;
    logic       in_acc;

    assign pop        = (r_count != 2'd0) && !i_out_stall;
    assign occ_after  = 3'(r_count) + 3'(r_s1_valid) - 3'(pop);
    assign o_in_stall = occ_after >= 3'd2;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Ranging sequencer. Control state lives in flip-flops; the per-sensor
    // readings live in a small synchronous memory.
    // ------------------------------------------------------------------
    t_phase      r_phase;
    t_phase      n_phase;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] n_cur;
    logic [16:0] r_tick_count;
    logic [16:0] n_tick_count;
    logic [7:0]  r_prescale;
    logic [7:0]  n_prescale;
    logic [7:0]  r_dist;
    logic [7:0]  n_dist;
    logic [3:0]  r_stored_count;
    logic [3:0]  n_stored_count;

    logic [16:0] cnt_inc;
    logic [8:0]  pre_inc;
    logic [7:0]  dist_step;
    logic [7:0]  echo_shift;
    logic        cur_on_pin;
    logic        echo_now;
    logic [SW-1:0] cur_next;
    logic        mem_wr;

    assign cnt_inc    = r_tick_count + 17'd1;
    assign pre_inc    = 9'(r_prescale) + 9'd1;
    assign echo_shift = i_echo_levels >> r_cur;
    // Sensors beyond the eighth have no pins: their echo reads low.
    assign cur_on_pin = 5'(r_cur) < 5'(umr_pkg::NUM_PINS);
    assign echo_now   = cur_on_pin && echo_shift[0];
    assign cur_next   = (r_cur == SW'(SENSORS - 1)) ? '0 : SW'(r_cur + SW'(1));

    // A unit is counted each time the prescaler reaches ticks_per_unit;
    // a zero setting therefore counts a unit on every echo tick.
    always_comb begin
        if (pre_inc >= 9'(r_ticks_per_unit)) begin
            n_prescale = 8'd0;
            dist_step  = (r_dist == umr_pkg::DIST_MAX) ? r_dist : r_dist + 8'd1;
        end else begin
            n_prescale = pre_inc[7:0];
            dist_step  = r_dist;
        end
    end

    logic [3:0] cmd_code;
    logic [3:0] cmd_arg;
    logic       arg_in_range;

    assign cmd_code     = i_rx_byte[7:4];
    assign cmd_arg      = i_rx_byte[3:0];
    assign arg_in_range = 5'(cmd_arg) < 5'(SENSORS);

    logic [7:0] prescale_next;

    always_comb begin
        n_phase        = r_phase;
        n_cur          = r_cur;
        n_tick_count   = r_tick_count;
        prescale_next  = r_prescale;
        n_dist         = r_dist;
        n_stored_count = r_stored_count;
        mem_wr         = 1'b0;
        if (in_acc && i_command) begin
            if (cmd_code == umr_pkg::CMD_SET_COUNT) begin
                n_stored_count = cmd_arg;
            end
        end else if (in_acc) begin
            case (r_phase)
                PH_TRIGGER: begin
                    // A zero width still holds the trigger for one tick.
                    if (cnt_inc >= 17'(r_trigger_width)) begin
                        n_phase      = PH_RISE;
                        n_tick_count = 17'd0;
                    end else begin
                        n_tick_count = cnt_inc;
                    end
                end
                PH_RISE: begin
                    if (cnt_inc > 17'(r_rise_wait_limit) || echo_now) begin
                        n_phase       = PH_ECHO;
                        n_tick_count  = 17'd0;
                        prescale_next = 8'd0;
                        n_dist        = 8'd0;
                    end else begin
                        n_tick_count = cnt_inc;
                    end
                end
                PH_ECHO: begin
                    prescale_next = n_prescale;
                    n_dist        = dist_step;
                    n_tick_count  = cnt_inc;
                    // The tick on which the echo falls still counts.
                    if (cnt_inc > 17'(r_echo_limit) || !echo_now) begin
                        mem_wr       = 1'b1;
                        n_tick_count = 17'd0;
                        if (r_gap_ticks == 17'd0) begin
                            n_phase = PH_TRIGGER;
                            n_cur   = cur_next;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end
                end
                default: begin
                    if (cnt_inc >= r_gap_ticks) begin
                        n_phase      = PH_TRIGGER;
                        n_cur        = cur_next;
                        n_tick_count = 17'd0;
                    end else begin
                        n_tick_count = cnt_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TRIGGER;
            r_cur          <= '0;
            r_tick_count   <= 17'd0;
            r_prescale     <= 8'd0;
            r_dist         <= 8'd0;
            r_stored_count <= umr_pkg::RST_STORED_COUNT;
        end else begin
            r_phase        <= n_phase;
            r_cur          <= n_cur;
            r_tick_count   <= n_tick_count;
            r_prescale     <= prescale_next;
            r_dist         <= n_dist;
            r_stored_count <= n_stored_count;
        end
    end

    // ------------------------------------------------------------------
    // Readings memory: one write port from the sequencer, one registered
    // read port for the read command. At most one request is taken per
    // edge, so a read always sees every earlier write without forwarding.
    // Valid bits stand in for a clear of the memory after reset.
    // ------------------------------------------------------------------
    logic [7:0]    r_readings [SENSORS];
    logic          r_entry_ok [SENSORS];
    logic [7:0]    r_rd_data;
    logic          r_rd_ok;
    logic          mem_rd;
    logic [SW-1:0] rd_idx;

    assign rd_idx = SW'(cmd_arg);
    assign mem_rd = in_acc && i_command && (cmd_code == umr_pkg::CMD_READ) && arg_in_range;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_readings[r_cur] <= dist_step;
        end
        if (mem_rd) begin
            r_rd_data <= r_readings[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SENSORS; k++) begin
                r_entry_ok[k] <= 1'b0;
            end
            r_rd_ok <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_entry_ok[r_cur] <= 1'b1;
            end
            if (mem_rd) begin
                r_rd_ok <= r_entry_ok[rd_idx];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage one: the reply for everything except a memory read is settled
    // at acceptance; the trigger levels reflect the state after the request.
    // ------------------------------------------------------------------
    logic       r_s1_use_mem;
    logic [7:0] r_s1_reply;
    logic       r_s1_reply_valid;
    logic [7:0] r_s1_trig;
    logic [7:0] reply_now;
    logic [7:0] trig_now;
    logic       next_on_pin;

    always_comb begin
        reply_now = umr_pkg::REPLY_OK;
        if (i_command) begin
            case (cmd_code)
                umr_pkg::CMD_NOP:       reply_now = umr_pkg::REPLY_OK;
                umr_pkg::CMD_SET_COUNT: reply_now = umr_pkg::REPLY_OK;
                umr_pkg::CMD_GET_COUNT: reply_now = {4'd0, r_stored_count};
                umr_pkg::CMD_READ:      reply_now = umr_pkg::REPLY_ERROR;
                default:                reply_now = umr_pkg::REPLY_ERROR;
            endcase
        end
    end

    assign next_on_pin = 5'(n_cur) < 5'(umr_pkg::NUM_PINS);
    assign trig_now    = (n_phase == PH_TRIGGER && next_on_pin) ? (8'd1 << n_cur) : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
        if (in_acc) begin
            r_s1_use_mem     <= mem_rd;
            r_s1_reply       <= reply_now;
            r_s1_reply_valid <= i_command;
            r_s1_trig        <= trig_now;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output queue.
    // ------------------------------------------------------------------
    logic [7:0] r_q_reply [2];
    logic       r_q_rv    [2];
    logic [7:0] r_q_trig  [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [7:0] push_reply;

    assign push_reply = r_s1_use_mem ? (r_rd_ok ? r_rd_data : 8'd0) : r_s1_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (r_s1_valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= 2'(3'(r_count) + 3'(r_s1_valid) - 3'(pop));
        end
        if (r_s1_valid) begin
            r_q_reply[r_wr_ptr] <= push_reply;
            r_q_rv[r_wr_ptr]    <= r_s1_reply_valid;
            r_q_trig[r_wr_ptr]  <= r_s1_trig;
        end
    end

    assign o_out_valid     = r_count != 2'd0;
    assign o_reply_byte    = r_q_reply[r_rd_ptr];
    assign o_reply_valid   = r_q_rv[r_rd_ptr];
    assign o_trigger_lines = r_q_trig[r_rd_ptr];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("output queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> r_count <= 2'd1)
        else $error("stage one pushed into a full queue");

    a_trig_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_trigger_lines))
        else $error("more than one trigger line high");

    a_rise_to_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_command && r_phase == PH_RISE && echo_now) |=> r_phase == PH_ECHO)
        else $error("echo rise did not start the measurement");

endmodule

// ===== tb/sv/tb.sv =====
module tb;

    localparam int RANGER_SENSORS = 8;
    // Cycles without any accepted request, reply or register access before we give up.
    localparam int STALL_LIMIT = 2000;
    // Length of the one long receiver hold-off that forces the block to back up.
    localparam int HOLD_OFF_CYCLES = 120;

    // Ranging sequence of one sensor slot.
    typedef enum logic [1:0] {
        STEP_TRIGGER,
        STEP_RISE,
        STEP_ECHO,
        STEP_GAP
    } ranger_step_t;

    typedef struct packed {
        logic [7:0] reply;
        logic       answered;
        logic [7:0] trigger;
    } ranger_reply_t;

    // Predicts every reply of the ranger and checks the replies in order.
    class ranger_scoreboard;
        logic [7:0]  trig_width;
        logic [15:0] rise_limit;
        logic [15:0] echo_limit;
        logic [7:0]  unit_ticks;
        logic [16:0] gap_len;

        logic [7:0]   distances [RANGER_SENSORS];
        logic [3:0]   kept_count;
        ranger_step_t step;
        int unsigned  sensor;
        int unsigned  ticks;
        int unsigned  prescale;
        int unsigned  acc_units;

        ranger_reply_t pending_replies[$];
        int errors;
        int n_requests;
        int n_commands;
        int n_checked;

        function new();
            trig_width = umr_pkg::RST_TRIGGER_WIDTH;
            rise_limit = umr_pkg::RST_RISE_WAIT_LIMIT;
            echo_limit = umr_pkg::RST_ECHO_LIMIT;
            unit_ticks = umr_pkg::RST_TICKS_PER_UNIT;
            gap_len    = umr_pkg::RST_GAP_TICKS;
            foreach (distances[k]) distances[k] = '0;
            kept_count = umr_pkg::RST_STORED_COUNT;
            step       = STEP_TRIGGER;
            sensor     = 0;
            ticks      = 0;
            prescale   = 0;
            acc_units  = 0;
            errors     = 0;
            n_requests = 0;
            n_commands = 0;
            n_checked  = 0;
        endfunction

        function void set_register(umr_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                umr_pkg::REG_TRIGGER_WIDTH:   trig_width = value[7:0];
                umr_pkg::REG_RISE_WAIT_LIMIT: rise_limit = value[15:0];
                umr_pkg::REG_ECHO_LIMIT:      echo_limit = value[15:0];
                umr_pkg::REG_TICKS_PER_UNIT:  unit_ticks = value[7:0];
                umr_pkg::REG_GAP_TICKS:       gap_len    = value[16:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void move_to_next_sensor();
            sensor = (sensor + 1) % RANGER_SENSORS;
            step   = STEP_TRIGGER;
            ticks  = 0;
        endfunction

        // One microsecond tick of the ranging sequence. A zero trigger width or a zero
        // unit length acts as one, which falls out of the compare order below.
        function void advance_tick(logic [7:0] levels);
            logic echo;
            echo = levels[sensor];
            ticks++;
            case (step)
                STEP_TRIGGER: begin
                    if (ticks >= trig_width) begin
                        step  = STEP_RISE;
                        ticks = 0;
                    end
                end
                STEP_RISE: begin
                    if (ticks > rise_limit || echo) begin
                        step      = STEP_ECHO;
                        ticks     = 0;
                        prescale  = 0;
                        acc_units = 0;
                    end
                end
                STEP_ECHO: begin
                    prescale++;
                    if (prescale >= unit_ticks) begin
                        prescale = 0;
                        if (acc_units < umr_pkg::DIST_MAX) acc_units++;
                    end
                    // The tick on which the echo is seen low still counts.
                    if (ticks > echo_limit || !echo) begin
                        distances[sensor] = acc_units[7:0];
                        if (gap_len == 0) begin
                            move_to_next_sensor();
                        end else begin
                            step  = STEP_GAP;
                            ticks = 0;
                        end
                    end
                end
                default: begin
                    if (ticks >= gap_len) move_to_next_sensor();
                end
            endcase
        endfunction

        function logic [7:0] answer_byte(logic [7:0] rx);
            logic [3:0] arg;
            arg = rx[3:0];
            case (umr_pkg::t_cmd'(rx[7:4]))
                umr_pkg::CMD_NOP: return umr_pkg::REPLY_OK;
                umr_pkg::CMD_SET_COUNT: begin
                    kept_count = arg;
                    return umr_pkg::REPLY_OK;
                end
                umr_pkg::CMD_GET_COUNT: return {4'd0, kept_count};
                umr_pkg::CMD_READ: begin
                    if (arg >= RANGER_SENSORS) return umr_pkg::REPLY_ERROR;
                    return distances[arg];
                end
                default: return umr_pkg::REPLY_ERROR;
            endcase
        endfunction

        function void note_request(logic is_cmd, logic [7:0] rx, logic [7:0] levels);
            ranger_reply_t r;
            r.reply    = '0;
            r.answered = is_cmd;
            if (is_cmd) begin
                r.reply = answer_byte(rx);
                n_commands++;
            end else begin
                advance_tick(levels);
            end
            r.trigger = (step == STEP_TRIGGER) ? 8'(1 << sensor) : 8'd0;
            pending_replies.push_back(r);
            n_requests++;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [7:0] reply, logic answered, logic [7:0] trigger);
            ranger_reply_t r;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with nothing expected, actual reply %0d valid %0d trig %0d",
                         $time, reply, answered, trigger);
                errors++;
                return;
            end
            r = pending_replies.pop_front();
            compare_field("reply_byte", r.reply, reply);
            compare_field("reply_valid", r.answered, answered);
            compare_field("trigger_lines", r.trigger, trigger);
            n_checked++;
        endfunction
    endclass

    ranger_scoreboard sb = new();

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_command     = 1'b0;
    logic [7:0]  i_rx_byte     = '0;
    logic [7:0]  i_echo_levels = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [7:0]  o_reply_byte;
    logic        o_reply_valid;
    logic [7:0]  o_trigger_lines;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    multi_ultrasonic_ranger_spi #(
        .SENSORS(RANGER_SENSORS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .i_echo_levels  (i_echo_levels),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_reply_byte   (o_reply_byte),
        .o_reply_valid  (o_reply_valid),
        .o_trigger_lines(o_trigger_lines),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle percentages for the sender and the receiver, changed per register setting.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Set by the stimulus to start the long hold-off; the receiver process times it.
    bit hold_off_req  = 1'b0;
    int hold_left     = 0;
    int settings_run  = 0;

    // Echo pulse shaping: the echo of the sensor being served alternates between
    // high and low runs of random length, so that rise waits, echo measurements and
    // timeouts all happen instead of random noise ending every phase at once.
    bit echo_on   = 1'b0;
    int run_left  = 0;

    // Receiver side: random stall, or the long hold-off once it has been asked for.
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Every reply taken at a rising edge is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reply(o_reply_byte, o_reply_valid, o_trigger_lines);
    end

    // Watchdog: any accepted request, reply or register access restarts the count.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL multi_ultrasonic_ranger_spi");
            $finish;
        end
    end

    // Offers one request and holds it until the block takes it. Called and left at a
    // falling edge; the sender may idle first, with valid low.
    task automatic send_request(logic is_cmd, logic [7:0] rx, logic [7:0] levels);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_command     = is_cmd;
        i_rx_byte     = rx;
        i_echo_levels = levels;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sb.note_request(is_cmd, rx, levels);
        @(negedge i_clk);
    endtask

    task automatic reg_write(umr_pkg::t_reg_idx idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read(umr_pkg::t_reg_idx idx, output logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Waits until every predicted reply has come back, then lets the
    // pipeline settle. Leaves at a falling edge with the sender idle.
    task automatic drain_replies(int settle);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Loads one register setting, reads it back, then runs a stretch of random
    // requests under the given idle mode.
    task automatic run_setting(logic [7:0] tw, logic [15:0] rise, logic [15:0] echo_lim,
                               logic [7:0] unit, logic [16:0] gap, int n_items,
                               int run_max, int idle_mode, bit with_hold_off);
        logic [31:0]       want [5];
        logic [31:0]       got;
        logic [7:0]        rx;
        logic [7:0]        lv;
        umr_pkg::t_reg_idx idx;
        int                pick;
        drain_replies(4);
        want = '{32'(tw), 32'(rise), 32'(echo_lim), 32'(unit), 32'(gap)};
        for (int k = 0; k < 5; k++) begin
            idx = umr_pkg::t_reg_idx'(k);
            reg_write(idx, want[k]);
        end
        for (int k = 0; k < 5; k++) begin
            idx = umr_pkg::t_reg_idx'(k);
            reg_read(idx, got);
            if (got !== want[k]) begin
                $display("%0t: readback of %s mismatch, expected %0d, actual %0d",
                         $time, idx.name(), want[k], got);
                sb.errors++;
            end
        end
        settings_run++;
        case (idle_mode)
            0: begin send_idle_pct = 12; recv_idle_pct = 74; end
            1: begin send_idle_pct = 74; recv_idle_pct = 12; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        for (int i = 0; i < n_items; i++) begin
            if (with_hold_off && i == 50) hold_off_req = 1'b1;
            rx = 8'($urandom_range(255));
            if ($urandom_range(3) == 0) begin
                // Mostly well-formed commands with random arguments, some raw bytes.
                pick = $urandom_range(9);
                if (pick < 4)       rx[7:4] = umr_pkg::CMD_READ;
                else if (pick == 4) rx[7:4] = umr_pkg::CMD_GET_COUNT;
                else if (pick == 5) rx[7:4] = umr_pkg::CMD_SET_COUNT;
                else if (pick == 6) rx[7:4] = umr_pkg::CMD_NOP;
                send_request(1'b1, rx, 8'($urandom_range(255)));
            end else begin
                if (run_left == 0) begin
                    echo_on  = !echo_on;
                    run_left = $urandom_range(run_max, 1);
                end
                run_left--;
                lv = 8'($urandom_range(255));
                // Now and then the served sensor's echo is pure noise.
                if ($urandom_range(7) != 0) lv[sb.sensor] = echo_on;
                send_request(1'b0, rx, lv);
            end
        end
    endtask

    // Command bytes for the directed part: every command, the argument extremes,
    // a read index just past the last sensor, and undefined commands.
    logic [7:0] probe_bytes [21] = '{
        8'h00, 8'h0F, 8'h20, 8'h1F, 8'h2A, 8'h10, 8'h25,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h3F, 8'h4C, 8'h80, 8'hF0, 8'hFF
    };

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset defaults: readings must read zero, the kept
        // count starts at eight, and the first trigger line is up right after reset.
        send_request(1'b0, 8'h00, 8'h00);
        send_request(1'b0, 8'hFF, 8'hFF);
        foreach (probe_bytes[k]) send_request(1'b1, probe_bytes[k], 8'($urandom_range(255)));
        send_request(1'b0, 8'h00, 8'hFF);
        send_request(1'b0, 8'hFF, 8'h00);

        // Short sequence with the long receiver hold-off partway through.
        run_setting(8'd1, 16'd4, 16'd40, 8'd2, 17'd3, 200, 20, 0, 1'b1);
        // Low extremes: zero trigger width, zero unit length and zero gap.
        run_setting(8'd0, 16'd1, 16'd1, 8'd0, 17'd0, 150, 5, 0, 1'b0);
        // High extremes; the sequence never gets past its trigger window here.
        run_setting(8'd255, 16'd65535, 16'd65535, 8'd255, 17'd131071, 60, 50, 1, 1'b0);
        // One tick per unit and long echoes, so readings saturate.
        run_setting(8'd2, 16'd6, 16'd400, 8'd1, 17'd1, 400, 300, 1, 1'b0);
        run_setting(8'd5, 16'd20, 16'd100, 8'd7, 17'd10, 200, 40, 2, 1'b0);
        run_setting(8'd1, 16'd2, 16'd65535, 8'd3, 17'd2, 290, 30, 2, 1'b0);

        drain_replies(10);
        $display("Checked %0d replies to %0d requests (%0d command bytes) over %0d settings.",
                 sb.n_checked, sb.n_requests, sb.n_commands, settings_run);
        $display("Register readback, long receiver hold-off and all three idle mixes ran.");
        if (sb.errors == 0) begin
            $display("PASS multi_ultrasonic_ranger_spi");
        end else begin
            $display("%0d mismatches found", sb.errors);
            $display("FAIL multi_ultrasonic_ranger_spi");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/umr_pkg.sv
design/multi_ultrasonic_ranger_spi.sv
tb/sv/tb.sv
